@@ src/assert_macros.svh @@
// Assertion shorthands shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication, held off while reset is asserted
`define AST_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ src/dqvd_pkg.sv @@
package dqvd_pkg;

	localparam int DEPTH      = 32;
	localparam int DATA_WIDTH = 32;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 4;
	localparam int VAL_W  = 32;
	localparam int DCNT_W = 6;
	localparam int OCC_W  = 6;
	localparam int STAT_W = 2;
	localparam int CMP_W  = (CNT_W > DCNT_W) ? CNT_W : DCNT_W;

	localparam int OFIFO_DEPTH = 3;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
	localparam int FILL_W      = $clog2(OFIFO_DEPTH + 1);

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 4'd0,
		CMD_PUSH_BACK  = 4'd1,
		CMD_POP_FRONT  = 4'd2,
		CMD_POP_BACK   = 4'd3,
		CMD_DELETE     = 4'd4,
		CMD_DUMP_ALL   = 4'd5,
		CMD_DUMP_FIRST = 4'd6,
		CMD_DUMP_LAST  = 4'd7,
		CMD_CLEAR      = 4'd8
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DUMP,
		S_DEL,
		S_DEL_END
	} fsm_t;

	typedef struct packed {
		logic [VAL_W-1:0]  entry_value;
		logic              entry_valid;
		logic              last;
		logic [OCC_W-1:0]  occupancy;
		logic [STAT_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		word_t wdata;
		ptr_t  raddr;
	} ram_req_t;

	typedef struct packed {
		logic idle;
		logic walking;
	} ctl_stat_t;

	// ring position of an offset from the front
	function automatic ptr_t slot(ptr_t base, ptr_t off);
		logic [PTR_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (PTR_W+1)'(DEPTH))
			s = s - (PTR_W+1)'(DEPTH);
		return s[PTR_W-1:0];
	endfunction

	function automatic ptr_t ptr_dec(ptr_t p);
		ptr_t r;
		if (p == '0)
			r = PTR_W'(DEPTH - 1);
		else
			r = p - PTR_W'(1);
		return r;
	endfunction

endpackage

@@ src/dqvd_chan_if.sv @@
interface dqvd_in_if;
	logic                             valid;
	logic                             ready;
	logic [dqvd_pkg::CMD_W-1:0]       cmd;
	logic signed [dqvd_pkg::VAL_W-1:0] value;
	logic [dqvd_pkg::DCNT_W-1:0]      dump_count;

	modport source (output valid, output cmd, output value, output dump_count, input ready);
	modport sink (input valid, input cmd, input value, input dump_count, output ready);
endinterface

interface dqvd_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [dqvd_pkg::VAL_W-1:0] entry_value;
	logic                              entry_valid;
	logic                              last;
	logic [dqvd_pkg::OCC_W-1:0]        occupancy;
	logic [dqvd_pkg::STAT_W-1:0]       status;

	modport source (output valid, output entry_value, output entry_valid, output last,
		output occupancy, output status, input ready);
	modport sink (input valid, input entry_value, input entry_valid, input last,
		input occupancy, input status, output ready);
endinterface

@@ src/dqvd_ram.sv @@
module dqvd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/dqvd_out_fifo.sv @@
module dqvd_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dqvd_pkg::res_t                din,
	dqvd_out_if.source                    rsp,
	output logic [dqvd_pkg::FILL_W-1:0]   fill
);

	dqvd_pkg::res_t                     mem_q [dqvd_pkg::OFIFO_DEPTH];
	logic [dqvd_pkg::OFIFO_AW-1:0]      wr_q;
	logic [dqvd_pkg::OFIFO_AW-1:0]      rd_q;
	logic [dqvd_pkg::FILL_W-1:0]        fill_q;
	logic                               pop;
	dqvd_pkg::res_t                     head;

	function automatic logic [dqvd_pkg::OFIFO_AW-1:0] wrap_inc(
		logic [dqvd_pkg::OFIFO_AW-1:0] p);
		logic [dqvd_pkg::OFIFO_AW-1:0] r;
		if (p == dqvd_pkg::OFIFO_AW'(dqvd_pkg::OFIFO_DEPTH - 1))
			r = '0;
		else
			r = p + dqvd_pkg::OFIFO_AW'(1);
		return r;
	endfunction

	assign pop  = rsp.valid && rsp.ready;
	assign fill = fill_q;
	assign head = mem_q[rd_q];

	assign rsp.valid       = (fill_q != '0);
	assign rsp.entry_value = head.entry_value;
	assign rsp.entry_valid = head.entry_valid;
	assign rsp.last        = head.last;
	assign rsp.occupancy   = head.occupancy;
	assign rsp.status      = head.status;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wrap_inc(wr_q);
			if (pop)
				rd_q <= wrap_inc(rd_q);
			if (push && !pop)
				fill_q <= fill_q + dqvd_pkg::FILL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - dqvd_pkg::FILL_W'(1);
		end
	end

endmodule

@@ src/dqvd_ctrl.sv @@
module dqvd_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	dqvd_in_if.sink                     req,
	input  dqvd_pkg::word_t             rdata,
	input  logic [dqvd_pkg::FILL_W-1:0] fill,
	output dqvd_pkg::ram_req_t          ram,
	output logic                        res_push,
	output dqvd_pkg::res_t              res,
	output dqvd_pkg::ctl_stat_t         stat
);

	dqvd_pkg::fsm_t  state_q, state_d;
	dqvd_pkg::ptr_t  front_q, front_d;
	dqvd_pkg::cnt_t  count_q, count_d;
	dqvd_pkg::ptr_t  off_q, off_d;
	dqvd_pkg::cnt_t  left_q, left_d;
	dqvd_pkg::cnt_t  kept_q, kept_d;
	dqvd_pkg::word_t word_q, word_d;

	logic                          res_vld_s1;
	logic                          res_ram_s1;
	logic                          res_last_s1;
	logic [dqvd_pkg::OCC_W-1:0]    res_occ_s1;
	logic [dqvd_pkg::STAT_W-1:0]   res_stat_s1;
	logic                          del_vld_s1;

	logic                          space;
	logic                          issue;
	logic                          iss_ram;
	logic                          iss_last;
	logic [dqvd_pkg::OCC_W-1:0]    iss_occ;
	dqvd_pkg::status_t             iss_stat;
	logic                          del_rd;
	logic                          push_we;
	dqvd_pkg::ptr_t                push_addr;
	logic                          del_we;
	dqvd_pkg::cnt_t                n_sat;
	dqvd_pkg::cnt_t                n_dump;
	dqvd_pkg::cnt_t                first_off;
	dqvd_pkg::word_t               in_word;

	// credit: everything in flight must fit in the output fifo
	assign space = ({1'b0, fill} + (dqvd_pkg::FILL_W+1)'(res_vld_s1))
		< (dqvd_pkg::FILL_W+1)'(dqvd_pkg::OFIFO_DEPTH);

	assign in_word = dqvd_pkg::word_t'(req.value);

	always_comb begin
		if (dqvd_pkg::CMP_W'(req.dump_count) > dqvd_pkg::CMP_W'(count_q))
			n_sat = count_q;
		else
			n_sat = dqvd_pkg::CNT_W'(req.dump_count);
		if (dqvd_pkg::cmd_t'(req.cmd) == dqvd_pkg::CMD_DUMP_ALL)
			n_dump = count_q;
		else
			n_dump = n_sat;
		first_off = count_q - n_dump;
	end

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		off_d     = off_q;
		left_d    = left_q;
		word_d    = word_q;
		issue     = 1'b0;
		iss_ram   = 1'b0;
		iss_last  = 1'b1;
		iss_occ   = dqvd_pkg::OCC_W'(count_q);
		iss_stat  = dqvd_pkg::ST_OK;
		del_rd    = 1'b0;
		push_we   = 1'b0;
		push_addr = front_q;
		req.ready = (state_q == dqvd_pkg::S_IDLE) && space;

		// compaction write-back of the entry read last cycle
		del_we = del_vld_s1 && (rdata != word_q);
		kept_d = kept_q + dqvd_pkg::CNT_W'(del_we);

		unique case (state_q)
			dqvd_pkg::S_IDLE: begin
				if (req.valid && space) begin
					word_d = in_word;
					unique case (dqvd_pkg::cmd_t'(req.cmd)) inside
						dqvd_pkg::CMD_PUSH_FRONT: begin
							issue = 1'b1;
							if (count_q == dqvd_pkg::CNT_W'(dqvd_pkg::DEPTH)) begin
								iss_stat = dqvd_pkg::ST_FULL;
							end else begin
								front_d   = dqvd_pkg::ptr_dec(front_q);
								push_we   = 1'b1;
								push_addr = front_d;
								count_d   = count_q + dqvd_pkg::CNT_W'(1);
								iss_occ   = dqvd_pkg::OCC_W'(count_d);
							end
						end
						dqvd_pkg::CMD_PUSH_BACK: begin
							issue = 1'b1;
							if (count_q == dqvd_pkg::CNT_W'(dqvd_pkg::DEPTH)) begin
								iss_stat = dqvd_pkg::ST_FULL;
							end else begin
								push_we   = 1'b1;
								push_addr = dqvd_pkg::slot(front_q,
									count_q[dqvd_pkg::PTR_W-1:0]);
								count_d   = count_q + dqvd_pkg::CNT_W'(1);
								iss_occ   = dqvd_pkg::OCC_W'(count_d);
							end
						end
						dqvd_pkg::CMD_POP_FRONT, dqvd_pkg::CMD_POP_BACK: begin
							issue = 1'b1;
							if (count_q == '0) begin
								iss_stat = dqvd_pkg::ST_EMPTY;
							end else begin
								if (dqvd_pkg::cmd_t'(req.cmd) == dqvd_pkg::CMD_POP_FRONT)
									front_d = dqvd_pkg::slot(front_q, dqvd_pkg::PTR_W'(1));
								count_d = count_q - dqvd_pkg::CNT_W'(1);
								iss_occ = dqvd_pkg::OCC_W'(count_d);
							end
						end
						dqvd_pkg::CMD_DELETE: begin
							kept_d = '0;
							off_d  = '0;
							if (count_q == '0)
								issue = 1'b1;
							else
								state_d = dqvd_pkg::S_DEL;
						end
						dqvd_pkg::CMD_DUMP_ALL, dqvd_pkg::CMD_DUMP_FIRST,
						dqvd_pkg::CMD_DUMP_LAST: begin
							if (n_dump == '0) begin
								issue = 1'b1;
							end else begin
								if (dqvd_pkg::cmd_t'(req.cmd) == dqvd_pkg::CMD_DUMP_LAST)
									off_d = first_off[dqvd_pkg::PTR_W-1:0];
								else
									off_d = '0;
								left_d  = n_dump;
								state_d = dqvd_pkg::S_DUMP;
							end
						end
						dqvd_pkg::CMD_CLEAR: begin
							issue   = 1'b1;
							count_d = '0;
							front_d = '0;
							iss_occ = '0;
						end
						default: begin
							issue = 1'b1;
						end
					endcase
				end
			end
			dqvd_pkg::S_DUMP: begin
				if (space) begin
					issue    = 1'b1;
					iss_ram  = 1'b1;
					iss_last = (left_q == dqvd_pkg::CNT_W'(1));
					off_d    = off_q + dqvd_pkg::PTR_W'(1);
					left_d   = left_q - dqvd_pkg::CNT_W'(1);
					if (left_q == dqvd_pkg::CNT_W'(1))
						state_d = dqvd_pkg::S_IDLE;
				end
			end
			dqvd_pkg::S_DEL: begin
				del_rd = 1'b1;
				off_d  = off_q + dqvd_pkg::PTR_W'(1);
				if (dqvd_pkg::CNT_W'(off_q) + dqvd_pkg::CNT_W'(1) == count_q)
					state_d = dqvd_pkg::S_DEL_END;
			end
			dqvd_pkg::S_DEL_END: begin
				// wait for the last compare to retire before reporting
				if (!del_vld_s1 && space) begin
					issue   = 1'b1;
					count_d = kept_q;
					iss_occ = dqvd_pkg::OCC_W'(kept_q);
					state_d = dqvd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dqvd_pkg::S_IDLE;
			end
		endcase

		ram.we    = push_we || del_we;
		ram.waddr = push_we ? push_addr
			: dqvd_pkg::slot(front_q, kept_q[dqvd_pkg::PTR_W-1:0]);
		ram.wdata = push_we ? in_word : rdata;
		ram.raddr = dqvd_pkg::slot(front_q, off_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dqvd_pkg::S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			off_q      <= '0;
			left_q     <= '0;
			kept_q     <= '0;
			res_vld_s1 <= 1'b0;
			del_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			off_q      <= off_d;
			left_q     <= left_d;
			kept_q     <= kept_d;
			res_vld_s1 <= issue;
			del_vld_s1 <= del_rd;
		end
	end

	always_ff @(posedge clk) begin
		word_q      <= word_d;
		res_ram_s1  <= iss_ram;
		res_last_s1 <= iss_last;
		res_occ_s1  <= iss_occ;
		res_stat_s1 <= iss_stat;
	end

	assign res_push        = res_vld_s1;
	assign res.entry_value = res_ram_s1 ? dqvd_pkg::VAL_W'(rdata) : '0;
	assign res.entry_valid = res_ram_s1;
	assign res.last        = res_last_s1;
	assign res.occupancy   = res_occ_s1;
	assign res.status      = res_stat_s1;

	assign stat.idle    = (state_q == dqvd_pkg::S_IDLE);
	assign stat.walking = (state_q == dqvd_pkg::S_DEL);

endmodule

@@ src/deque_with_value_delete.sv @@
// Push, pop, clear and unused codes: the result is registered and then queued in the
// output fifo; a new request may follow every cycle while the output fifo has room.
// Dump of n entries: one entry per cycle while the output fifo has room, one
// memory read each. Delete value: walks the entries, one entry per cycle, then reports (at once when empty).
// Reset (arst_n low) empties the queue; stored words stay undefined until pushed.
`include "assert_macros.svh"

module deque_with_value_delete (
	input  logic       clk,
	input  logic       arst_n,
	dqvd_in_if.sink    req,
	dqvd_out_if.source rsp
);

	dqvd_pkg::ram_req_t          ram;
	dqvd_pkg::word_t             rdata;
	dqvd_pkg::res_t              res;
	dqvd_pkg::ctl_stat_t         stat;
	logic                        res_push;
	logic [dqvd_pkg::FILL_W-1:0] fill;

	dqvd_ram #(
		.WIDTH (dqvd_pkg::DATA_WIDTH),
		.DEPTH (dqvd_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	dqvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.fill     (fill),
		.ram      (ram),
		.res_push (res_push),
		.res      (res),
		.stat     (stat)
	);

	dqvd_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.rsp    (rsp),
		.fill   (fill)
	);

	`AST_IMP(a_fifo_bound, clk, arst_n, 1'b1, fill <= dqvd_pkg::FILL_W'(dqvd_pkg::OFIFO_DEPTH))
	`AST_IMP(a_del_no_clash, clk, arst_n, stat.walking && ram.we, ram.waddr != ram.raddr)
	`AST_IMP(a_req_only_idle, clk, arst_n, req.ready, stat.idle)
	`AST_NXT(a_walk_quiet, clk, arst_n, stat.walking, !res_push)

endmodule
